// File: design/rk4_logistic_system_step_defines.svh
// Assertion macros for rk4_logistic_system_step
`ifndef RK4_LOGISTIC_SYSTEM_STEP_DEFINES_SVH
`define RK4_LOGISTIC_SYSTEM_STEP_DEFINES_SVH
// implication checked on every clock unless in reset
`define RK4_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define RK4_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// File: design/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg
// Types and constants shared by the RK4 logistic system stepper.
// ----------------------------------------------------------------------------
package rk4_pkg;
   localparam int unsigned QFRAC = 24;
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;
   localparam logic [0:0] CSR_STEP_SIZE    = 1'b0;
   localparam logic [0:0] CSR_ACTIVE_COUNT = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [3:0]         var_index;
      logic signed [31:0] init_value;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         var_index_res;
      logic signed [31:0] new_value;
      logic               last;
   } rsp_item_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] r;
      if (v > 72'sh7FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -72'sh80000000) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [35:0] sat36(input logic signed [39:0] v);
      logic signed [35:0] r;
      if (v > 40'sh7FFFFFFFF) r = 36'sh7FFFFFFFF;
      else if (v < -40'sh800000000) r = 36'sh800000000;
      else r = v[35:0];
      return r;
   endfunction
endpackage

// File: design/rk4_logistic_system_step.sv
// ----------------------------------------------------------------------------
// rk4_logistic_system_step
// RK4 stepper for dx_i/dt = x_i - x_i*S over up to 16 variables, Q8.24.
// ----------------------------------------------------------------------------
// A load item is taken while busy stays low, so loads can follow back to
// back. An advance item with n active variables keeps busy high while the
// stage-point and accumulator memories are swept one entry a cycle: a pass
// to copy positions, then per stage a sum pass and an update pass (n issues
// plus the multiply pipeline drain), then the divide-by-six output pass.
// Results come out one per cycle at the end on rsp_valid and cannot be
// held off; busy falls in the cycle the last item is presented.
module rk4_logistic_system_step
   import rk4_pkg::*;
#(
   parameter int VAR_COUNT = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [30:0]  csr_wdata
);
   localparam int AW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
   localparam int LIM = (VAR_COUNT < 16) ? VAR_COUNT : 16;
   localparam int CW = $clog2(LIM + 1) + 1;

   localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_SUM = 3'd2,
                          S_UPD = 3'd3, S_OUT = 3'd4;

   logic [30:0] step_ff;
   logic [4:0]  act_ff;

   // memories: positions (reset by valid bits), stage points, accumulators
   logic signed [31:0] pos_mem [VAR_COUNT];
   logic [VAR_COUNT-1:0] pos_vld_ff;
   logic signed [31:0] pt_mem [VAR_COUNT];
   logic signed [35:0] acc_mem [VAR_COUNT];
   logic signed [31:0] pos_rd_ff, pt_rd_ff;
   logic signed [35:0] acc_rd_ff;
   logic               pos_rv_ff;

   logic [2:0]    st_ff;
   logic [1:0]    stage_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] n_ff;
   logic signed [39:0] sum_ff;
   logic signed [35:0] ssum_ff;

   // pipeline valid/index shift for update pass
   logic [5:0] pv_ff;
   logic [AW-1:0] pi_ff [6];
   logic signed [31:0] y1_ff, b1_ff;
   logic signed [71:0] prod_ff;
   logic signed [31:0] y2_ff, b2_ff, xs_ff, f_ff, b3_ff, b4_ff, k_ff;
   logic signed [63:0] hf_ff;
   logic signed [35:0] a5_ff;
   logic signed [31:0] b5_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] acc_addr;
   logic [AW-1:0] cnt_a;
   assign cnt_a = cnt_ff[AW-1:0];

   logic [CW-1:0] n_eff;
   always_comb begin
      n_eff = CW'(act_ff);
      if (act_ff == 5'd0) n_eff = CW'(1);
      if (act_ff > 5'(LIM)) n_eff = CW'(LIM);
   end

   assign busy = (st_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 31'd3355443;
         act_ff  <= 5'd16;
      end else if (csr_we) begin
         if (csr_index == CSR_STEP_SIZE) step_ff <= csr_wdata;
         else act_ff <= csr_wdata[4:0];
      end
   end

   assign rd_addr = (st_ff == S_UPD) ? cnt_a :
                    (st_ff == S_OUT) ? cnt_a : cnt_a;
   // update pass reads the accumulator late so it lines up with k
   assign acc_addr = (st_ff == S_UPD) ? pi_ff[3] : rd_addr;

   // synchronous reads
   always_ff @(posedge clock) begin
      pos_rd_ff <= pos_mem[rd_addr];
      pos_rv_ff <= pos_vld_ff[rd_addr];
      pt_rd_ff  <= pt_mem[rd_addr];
      acc_rd_ff <= acc_mem[acc_addr];
   end

   logic signed [31:0] pos_rd;
   assign pos_rd = pos_rv_ff ? pos_rd_ff : 32'sd0;

   // pipeline arithmetic
   logic signed [71:0] xs_sh;
   logic signed [31:0] mul_xs;
   logic signed [31:0] k_half, nv;
   logic signed [35:0] acc_new;
   logic signed [35:0] q6;
   logic signed [31:0] pt_new;
   assign xs_sh = prod_ff >>> QFRAC;
   assign mul_xs = sat32(xs_sh);
   assign k_half = k_ff >>> 1;
   always_comb begin
      case (stage_ff)
         2'd0, 2'd3: acc_new = a5_ff + 36'(k_ff);
         default:    acc_new = a5_ff + (36'(k_ff) <<< 1);
      endcase
      if (stage_ff == 2'd2) pt_new = sat32(72'(b5_ff) + 72'(k_ff));
      else pt_new = sat32(72'(b5_ff) + 72'(k_half));
   end

   // floor(acc/6): reciprocal multiply then fix by compare
   logic signed [35:0] d6_ff;
   logic signed [31:0] d6pos_ff, d6pos2_ff;
   logic               d6v_ff, d6v2_ff, d6v3_ff;
   logic [AW-1:0]      d6i_ff, d6i2_ff, d6i3_ff;
   logic signed [39:0] q0;
   logic signed [39:0] rem;
   logic signed [75:0] rq;
   assign rq = 76'(d6_ff) * 76'sd11453246123;   // ~2^36/6
   always_comb begin
      q0 = 40'(rq >>> 36);
      rem = 40'(d6_ff) - q0 * 40'sd6;
      if (rem >= 40'sd6) q0 = q0 + 40'sd1;
      else if (rem < 40'sd0) q0 = q0 - 40'sd1;
      q6 = q0[35:0];
   end
   logic signed [35:0] q6_ff;
   assign nv = sat32(72'(d6pos2_ff) + 72'(q6_ff));

   logic [CW-1:0] emit_ff;

   always_ff @(posedge clock) begin
      // update pipeline payload
      y1_ff   <= pt_rd_ff;
      b1_ff   <= pos_rd;
      prod_ff <= 72'(pt_rd_ff) * 72'(ssum_ff);
      y2_ff   <= y1_ff;
      b2_ff   <= b1_ff;
      xs_ff   <= mul_xs;
      f_ff    <= sat32(72'(y2_ff) - 72'(xs_ff));
      b3_ff   <= b2_ff;
      hf_ff   <= 64'($signed({1'b0, step_ff})) * 64'(f_ff);
      b4_ff   <= b3_ff;
      k_ff    <= sat32(72'(hf_ff >>> QFRAC));
      b5_ff   <= b4_ff;
      a5_ff   <= acc_rd_ff;
      d6_ff   <= acc_rd_ff;
      d6pos_ff <= pos_rd;
      d6pos2_ff <= d6pos_ff;
      q6_ff   <= q6;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         stage_ff <= 2'd0;
         cnt_ff <= '0;
         n_ff <= CW'(1);
         pos_vld_ff <= '0;
         pv_ff <= '0;
         sum_ff <= '0;
         ssum_ff <= '0;
         rsp_valid <= 1'b0;
         d6v_ff <= 1'b0;
         d6v2_ff <= 1'b0;
         d6v3_ff <= 1'b0;
         emit_ff <= '0;
      end else begin
         rsp_valid <= 1'b0;
         pv_ff <= {pv_ff[4:0], 1'b0};
         for (int j = 5; j > 0; j--) pi_ff[j] <= pi_ff[j-1];
         d6v_ff <= 1'b0;
         d6v2_ff <= d6v_ff;
         d6v3_ff <= d6v2_ff;
         d6i2_ff <= d6i_ff;
         d6i3_ff <= d6i2_ff;
         case (st_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_data.cmd == CMD_LOAD) begin
                     if (32'(req_data.var_index) < 32'(VAR_COUNT)) begin
                        pos_mem[AW'(req_data.var_index)] <= req_data.init_value;
                        pos_vld_ff[AW'(req_data.var_index)] <= 1'b1;
                     end
                  end else begin
                     n_ff <= n_eff;
                     cnt_ff <= '0;
                     st_ff <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               // copy positions into stage points, clear accumulators
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff != '0) begin
                  pt_mem[AW'(cnt_ff - CW'(1))] <= pos_rd;
                  acc_mem[AW'(cnt_ff - CW'(1))] <= '0;
               end
               if (cnt_ff == n_ff) begin
                  cnt_ff <= '0;
                  sum_ff <= '0;
                  stage_ff <= 2'd0;
                  st_ff <= S_SUM;
               end
            end
            S_SUM: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff != '0) sum_ff <= sum_ff + 40'(pt_rd_ff);
               if (cnt_ff == n_ff) begin
                  ssum_ff <= sat36(sum_ff + 40'(pt_rd_ff));
                  cnt_ff <= '0;
                  st_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (cnt_ff < n_ff) begin
                  cnt_ff <= cnt_ff + CW'(1);
                  pi_ff[0] <= cnt_a;
                  pv_ff[0] <= 1'b1;
               end
               if (pv_ff[5]) begin
                  acc_mem[pi_ff[5]] <= acc_new;
                  if (stage_ff != 2'd3) pt_mem[pi_ff[5]] <= pt_new;
               end
               if (cnt_ff == n_ff && pv_ff == 6'b100000) begin
                  cnt_ff <= '0;
                  sum_ff <= '0;
                  stage_ff <= stage_ff + 2'd1;
                  st_ff <= (stage_ff == 2'd3) ? S_OUT : S_SUM;
                  emit_ff <= '0;
               end
            end
            S_OUT: begin
               if (cnt_ff < n_ff) begin
                  cnt_ff <= cnt_ff + CW'(1);
                  d6v_ff <= 1'b1;
                  d6i_ff <= cnt_a;
               end
               if (d6v3_ff) begin
                  pos_mem[d6i3_ff] <= nv;
                  pos_vld_ff[d6i3_ff] <= 1'b1;
                  rsp_valid <= 1'b1;
                  rsp_data.var_index_res <= 4'(d6i3_ff);
                  rsp_data.new_value <= nv;
                  rsp_data.last <= (emit_ff + CW'(1) == n_ff);
                  emit_ff <= emit_ff + CW'(1);
                  if (emit_ff + CW'(1) == n_ff) st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // d6 timing: read data registered with d6v_ff, then d6_ff/d6pos_ff, then
   // q6_ff/d6pos2_ff, lined up with d6v3_ff

   `include "rk4_logistic_system_step_defines.svh"
   `RK4_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy || rsp_data.last, "result while idle")
   `RK4_ASSERT_IMP(a_last_idle, clock, reset, rsp_valid && rsp_data.last, !busy, "busy at last")
   `RK4_ASSERT_IMP(a_cnt_rng, clock, reset, busy, cnt_ff <= n_ff, "counter past active count")
endmodule

// File: tb/rk4_logistic_system_step_tb.sv
// ----------------------------------------------------------------------------
// rk4_logistic_system_step_tb
// Self-checking bench for the RK4 logistic system stepper. Load items set
// initial values and advance items run one RK4 step. A behavioral model
// predicts every reported value. Phases change step size and active count
// while the block is idle. Random start gaps exercise the command handshake.
// ----------------------------------------------------------------------------
module rk4_logistic_system_step_tb;
   import rk4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVARS       = 16;
   localparam int ITEMS_PHASE = 68;
   localparam int STALL_LIMIT = 4000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_data;
   logic         rsp_valid;
   rsp_item_type rsp_data;
   logic         csr_we;
   logic         csr_index;
   logic [30:0]  csr_wdata;

   rk4_logistic_system_step #(.VAR_COUNT(NVARS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   req_item_type pending_items[$];
   rsp_item_type expected_values[$];
   int   errors = 0;
   int   loads_done = 0;
   int   steps_done = 0;
   int   values_checked = 0;
   int   stall_cycles = 0;
   bit   no_gaps = 0;

   // model state
   logic signed [31:0] position[NVARS];
   longint             step_h;
   logic [4:0]         active_reg;

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   function automatic logic signed [31:0] clip32(input logic signed [71:0] v);
      if (v > 72'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -72'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] scaled_product(input logic signed [31:0] x,
                                                          input longint s);
      logic signed [71:0] a;
      logic signed [71:0] b;
      a = x;
      b = s;
      return clip32((a * b) >>> QFRAC);
   endfunction

   task automatic predict_item(input req_item_type it);
      int                 n;
      longint             s;
      longint             acc[NVARS];
      longint             q;
      logic signed [31:0] y[NVARS];
      logic signed [31:0] f;
      logic signed [31:0] k;
      rsp_item_type       r;
      if (it.cmd == CMD_LOAD) begin
         position[it.var_index] = it.init_value;
         loads_done++;
      end else begin
         steps_done++;
         n = int'(active_reg);
         if (n < 1) n = 1;
         if (n > NVARS) n = NVARS;
         for (int i = 0; i < n; i++) begin
            y[i] = position[i];
            acc[i] = 0;
         end
         for (int st = 0; st < 4; st++) begin
            s = 0;
            for (int i = 0; i < n; i++) s += y[i];
            if (s > 64'sh7FFFFFFFF) s = 64'sh7FFFFFFFF;
            if (s < -64'sh800000000) s = -64'sh800000000;
            for (int i = 0; i < n; i++) begin
               f = clip32(longint'(y[i]) - longint'(scaled_product(y[i], s)));
               k = clip32((step_h * longint'(f)) >>> QFRAC);
               acc[i] += (st == 1 || st == 2) ? 2 * longint'(k) : longint'(k);
               if (st < 2) y[i] = clip32(longint'(position[i]) + (longint'(k) >>> 1));
               else if (st == 2) y[i] = clip32(longint'(position[i]) + longint'(k));
            end
         end
         for (int i = 0; i < n; i++) begin
            q = acc[i] / 6;
            if (acc[i] % 6 < 0) q--;
            position[i] = clip32(longint'(position[i]) + q);
            r.var_index_res = i[3:0];
            r.new_value = position[i];
            r.last = (i == n - 1);
            expected_values.push_back(r);
         end
      end
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) predict_item(req_data);
         if (pending_items.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
            start <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_values.size() == 0) begin
            report($sformatf("unexpected result var %0d value %h",
                             rsp_data.var_index_res, rsp_data.new_value));
         end else begin
            rsp_item_type e;
            e = expected_values.pop_front();
            values_checked++;
            if (rsp_data.var_index_res !== e.var_index_res)
               report($sformatf("var index %0d, expected %0d",
                                rsp_data.var_index_res, e.var_index_res));
            if (rsp_data.new_value !== e.new_value)
               report($sformatf("var %0d value %h, expected %h",
                                e.var_index_res, rsp_data.new_value, e.new_value));
            if (rsp_data.last !== e.last)
               report($sformatf("var %0d last %b, expected %b",
                                e.var_index_res, rsp_data.last, e.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("rk4_logistic_system_step_tb NOT OK");
         $finish;
      end
   end

   task automatic write_csr(input logic idx, input logic [30:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_STEP_SIZE) step_h = longint'(val);
      else active_reg = val[4:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || expected_values.size() != 0 || start || busy);
      repeat (20) @(negedge clock);
   endtask

   task automatic queue_item(input logic c, input logic [3:0] idx,
                             input logic signed [31:0] v);
      req_item_type it;
      it.cmd = c;
      it.var_index = idx;
      it.init_value = v;
      pending_items.push_back(it);
   endtask

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      if (sel < 8) return $urandom_range(0, 32'h0100_0000);
      return $urandom;
   endfunction

   initial begin
      logic [30:0] h_val;
      logic [30:0] n_val;
      int          count;
      int          loads;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_STEP_SIZE;
      csr_wdata = '0;
      step_h = 3355443;
      active_reg = 5'd16;
      for (int i = 0; i < NVARS; i++) position[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every index, both commands
      queue_item(CMD_ADVANCE, 4'hF, 32'sh7FFFFFFF);
      queue_item(CMD_LOAD, 4'd0, 32'sh7FFFFFFF);
      queue_item(CMD_LOAD, 4'd1, 32'sh80000000);
      queue_item(CMD_LOAD, 4'd2, 32'sh0100_0000);
      queue_item(CMD_LOAD, 4'd3, -32'sd1);
      queue_item(CMD_ADVANCE, 4'd0, 32'sh0);
      for (int i = 0; i < NVARS; i++) queue_item(CMD_LOAD, i[3:0], 32'sh0008_0000 + i);
      queue_item(CMD_ADVANCE, 4'd5, 32'sh5555_AAAA);
      queue_item(CMD_ADVANCE, 4'hA, -32'sh5555_AAAA);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin h_val = '0; n_val = 31'd0; end
            1: begin h_val = 31'h7FFF_FFFF; n_val = 31'd1; end
            2: begin h_val = 31'($urandom_range(0, 32'h0200_0000)); n_val = 31'd31; end
            3: begin h_val = 31'($urandom); n_val = 31'($urandom_range(0, 31)); end
            4: begin h_val = 31'h0100_0000; n_val = 31'd16; end
            default: begin h_val = 31'($urandom_range(0, 32'h0080_0000));
                           n_val = 31'($urandom_range(1, 16)); end
         endcase
         no_gaps = (p == 4);
         write_csr(CSR_STEP_SIZE, h_val);
         write_csr(CSR_ACTIVE_COUNT, n_val);
         count = 0;
         while (count < ITEMS_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_item(1'($urandom_range(0, 1)), 4'($urandom), $urandom);
               count++;
            end else begin
               loads = $urandom_range(0, 5);
               for (int j = 0; j < loads; j++)
                  queue_item(CMD_LOAD, 4'($urandom_range(0, 15)), pick_value());
               queue_item(CMD_ADVANCE, 4'($urandom), $urandom);
               count += loads + 1;
            end
         end
         wait_idle();
      end

      repeat (200) @(negedge clock);
      while (expected_values.size() > 0) begin
         rsp_item_type e;
         e = expected_values.pop_front();
         report($sformatf("missing result for var %0d", e.var_index_res));
      end
      $display("covered %0d loads and %0d RK4 steps over 7 settings of h and active count",
               loads_done, steps_done);
      $display("%0d reported values compared, %0d mismatches", values_checked, errors);
      if (errors == 0) $display("rk4_logistic_system_step_tb OK");
      else $display("rk4_logistic_system_step_tb NOT OK");
      $finish;
   end
endmodule

// File: rk4_logistic_system_step.f
+incdir+design
design/rk4_pkg.sv
design/rk4_logistic_system_step.sv
tb/rk4_logistic_system_step_tb.sv
